[rtl/core/sric_pkg.sv]
// ----------------------------------------------------------------------------
// sric_pkg
// Shared types and constants of the sorted ring index cache.
// ----------------------------------------------------------------------------
package sric_pkg;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int SLOT_W = 10;
    localparam int IN_DATA_W  = 128;   // key, entry_value
    localparam int OUT_DATA_W = 80;    // found_value, found_slot, zero fill

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    // controller -> datapath
    typedef struct packed {
        logic append;     // write the incoming item into the ring
        logic seg0_init;  // latch search key, start on newest/only segment
        logic seg1_init;  // start on oldest segment of a wrapped ring
        logic rd;         // read the probe slot
        logic step;       // narrow the search window after a compare
        logic load_out;   // move the search outcome into the output register
        logic hit;        // outcome is a match
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic active;     // window not empty
        logic seg_more;   // oldest segment still to be searched
        logic eq;         // probe key equals search key
        logic out_free;   // output register can take a result this cycle
    } t_dp_sts;

endpackage

[rtl/core/sric_ctrl.sv]
// ----------------------------------------------------------------------------
// sric_ctrl
// Sequencer for append and binary search items.
// ----------------------------------------------------------------------------
module sric_ctrl
    import sric_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_hit, n_hit;
    logic   w_fire;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_fire     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    if (t_opcode'(i_opcode) == OP_APPEND) begin
                        o_cmd.append = 1'b1;
                    end else begin
                        o_cmd.seg0_init = 1'b1;
                        n_state         = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (i_sts.active) begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_CMP;
                end else if (i_sts.seg_more) begin
                    o_cmd.seg1_init = 1'b1;
                end else begin
                    n_hit   = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_CMP: begin
                if (i_sts.eq) begin
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.hit      = r_hit;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
        end
    end

endmodule

[rtl/core/sric_dpath.sv]
// ----------------------------------------------------------------------------
// sric_dpath
// Ring memories, fill/pointer state, search window and output register.
// ----------------------------------------------------------------------------
module sric_dpath
    import sric_pkg::*;
#(
    parameter int CAPACITY = 1024
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [VAL_W-1:0]    i_value,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_found,
    output logic [VAL_W-1:0]    o_found_value,
    output logic [SLOT_W-1:0]   o_found_slot
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];

    logic [CW-1:0]    r_fill;
    logic [AW-1:0]    r_wp;
    logic [KEY_W-1:0] r_key;
    logic [AW-1:0]    r_base;
    logic [CW-1:0]    r_lo, r_hi;
    logic             r_seg1;
    logic [AW-1:0]    r_rd_addr;
    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_val;

    logic             r_out_valid;
    logic             r_found;
    logic [VAL_W-1:0] r_found_value;
    logic [SLOT_W-1:0] r_found_slot;

    logic             w_full, w_wrapped;
    logic [CW:0]      w_sum;
    logic [CW-1:0]    w_mid;
    logic [AW-1:0]    w_probe;
    logic [AW-1:0]    w_wr_addr;
    logic [AW+SLOT_W-1:0] w_slot_ext;

    assign w_full    = (r_fill == CW'(CAPACITY));
    assign w_wrapped = w_full && (r_wp != '0);
    assign w_sum     = (CW+1)'(r_lo) + (CW+1)'(r_hi);
    assign w_mid     = w_sum[CW:1];
    assign w_probe   = AW'(CW'(r_base) + w_mid);
    assign w_wr_addr = w_full ? r_wp : AW'(r_fill);
    assign w_slot_ext = (AW+SLOT_W)'(r_rd_addr);

    assign o_sts.active   = (r_lo < r_hi);
    assign o_sts.seg_more = !r_seg1 && w_wrapped;
    assign o_sts.eq       = (r_rd_key == r_key);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // ring memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            key_mem[w_wr_addr] <= i_key;
            val_mem[w_wr_addr] <= i_value;
        end
        if (i_cmd.rd) begin
            r_rd_key <= key_mem[w_probe];
            r_rd_val <= val_mem[w_probe];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_wp   <= '0;
        end else if (i_cmd.append) begin
            if (w_full) begin
                r_wp <= (r_wp == AW'(CAPACITY - 1)) ? '0 : AW'(r_wp + 1'b1);
            end else begin
                r_fill <= CW'(r_fill + 1'b1);
            end
        end
    end

    // search window
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg0_init) begin
            r_key  <= i_key;
            r_base <= '0;
            r_lo   <= '0;
            r_hi   <= w_wrapped ? CW'(r_wp) : r_fill;
            r_seg1 <= 1'b0;
        end else if (i_cmd.seg1_init) begin
            r_base <= r_wp;
            r_lo   <= '0;
            r_hi   <= CW'(CAPACITY) - CW'(r_wp);
            r_seg1 <= 1'b1;
        end else if (i_cmd.step) begin
            if ($signed(r_key) > $signed(r_rd_key)) begin
                r_lo <= CW'(w_mid + 1'b1);
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.rd) begin
            r_rd_addr <= w_probe;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_found       <= i_cmd.hit;
            r_found_value <= i_cmd.hit ? r_rd_val : '0;
            r_found_slot  <= i_cmd.hit ? w_slot_ext[SLOT_W-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_found_value = r_found_value;
    assign o_found_slot  = r_found_slot;

endmodule

[rtl/core/sorted_ring_index_cache_top.sv]
// ----------------------------------------------------------------------------
// sorted_ring_index_cache_top
// Ring of recent key/value pairs with binary search over sorted segments.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | key[63:0], entry_value[127:64]             | opcode
//  m_axis   | out | found_value[63:0], found_slot[73:64], 0s   | found
//
//  Append: no result. Search: each probe presents the address, then
//  compares the registered memory read; when the ring has wrapped and
//  the newest segment misses, the oldest segment is probed as well.
//  Synchronous active-low reset clears fill count, write pointer and control;
//  ring contents stay undefined until written. One item is in work at a time;
//  a held result stalls the next search only at its final output load.
// ----------------------------------------------------------------------------
module sorted_ring_index_cache_top
    import sric_pkg::*;
#(
    parameter int CAPACITY = 1024
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key, entry_value
    input  logic                  s_axis_tuser,   // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // found_value, found_slot, 0s
    output logic                  m_axis_tuser    // found
);

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [VAL_W-1:0]  w_found_value;
    logic [SLOT_W-1:0] w_found_slot;

    sric_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sric_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_key         (s_axis_tdata[KEY_W-1:0]),
        .i_value       (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_found       (m_axis_tuser),
        .o_found_value (w_found_value),
        .o_found_slot  (w_found_slot)
    );

    assign m_axis_tdata = {(OUT_DATA_W-VAL_W-SLOT_W)'(0), w_found_slot, w_found_value};

endmodule

[bench/tb_sorted_ring_index_cache_top.sv]
// ----------------------------------------------------------------------------
// tb_sorted_ring_index_cache_top
// Self-checking bench for the sorted ring index cache. A scoreboard keeps its
// own copy of the ring and works out every search outcome as items are
// accepted. Stimulus covers empty, partly filled, full and wrapped rings,
// signed key extremes and out-of-order keys, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_sorted_ring_index_cache_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sric_pkg::*;

    localparam int          RING_DEPTH  = 1024;
    localparam int          RAND_ITEMS  = 1580;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_LIMIT = 20000;
    localparam int          DRAIN_TAIL  = 60;
    localparam logic [63:0] KEY_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_MAX     = 64'h7fff_ffff_ffff_ffff;

    typedef struct packed {
        logic              hit;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
    } t_lookup;

    // Shadow ring plus queue of search outcomes still owed by the block.
    class ring_scoreboard;
        logic [KEY_W-1:0] key_mem [RING_DEPTH];
        logic [VAL_W-1:0] val_mem [RING_DEPTH];
        int unsigned      fill_cnt  = 0;
        int unsigned      wr_ptr    = 0;
        t_lookup          lookups_due[$];
        int unsigned      errors    = 0;
        int unsigned      n_append  = 0;
        int unsigned      n_search  = 0;
        int unsigned      n_hit     = 0;
        int unsigned      n_split   = 0;
        int unsigned      n_checked = 0;

        function bit probe_segment(int unsigned base, int unsigned span,
                                   logic [KEY_W-1:0] key, output int unsigned slot);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo   = 0;
            hi   = span;
            slot = 0;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if ($signed(key) < $signed(key_mem[base + mid])) begin
                    hi = mid;
                end else if ($signed(key) > $signed(key_mem[base + mid])) begin
                    lo = mid + 1;
                end else begin
                    slot = base + mid;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_item(t_opcode op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
            t_lookup     due;
            int unsigned slot;
            bit          hit;
            if (op == OP_APPEND) begin
                n_append++;
                if (fill_cnt < RING_DEPTH) begin
                    key_mem[fill_cnt] = key;
                    val_mem[fill_cnt] = val;
                    fill_cnt++;
                end else begin
                    key_mem[wr_ptr] = key;
                    val_mem[wr_ptr] = val;
                    wr_ptr = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
                end
            end else begin
                n_search++;
                // wrapped ring: newest segment first, then the oldest
                if (fill_cnt == RING_DEPTH && wr_ptr != 0) begin
                    n_split++;
                    hit = probe_segment(0, wr_ptr, key, slot);
                    if (!hit) hit = probe_segment(wr_ptr, RING_DEPTH - wr_ptr, key, slot);
                end else begin
                    hit = probe_segment(0, fill_cnt, key, slot);
                end
                if (hit) n_hit++;
                due.hit   = hit;
                due.value = hit ? val_mem[slot] : '0;
                due.slot  = hit ? SLOT_W'(slot) : '0;
                lookups_due.push_back(due);
            end
        endfunction

        function void check_result(t_lookup got);
            t_lookup want;
            if (lookups_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0b value=%h slot=%0d",
                         $time, got.hit, got.value, got.slot);
                return;
            end
            want = lookups_due.pop_front();
            n_checked++;
            if (got.hit !== want.hit) begin
                errors++;
                $display("%0t: found mismatch: expected %0b actual %0b",
                         $time, want.hit, got.hit);
            end
            if (got.value !== want.value) begin
                errors++;
                $display("%0t: found_value mismatch: expected %h actual %h",
                         $time, want.value, got.value);
            end
            if (got.slot !== want.slot) begin
                errors++;
                $display("%0t: found_slot mismatch: expected %0d actual %0d",
                         $time, want.slot, got.slot);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // key, entry_value
    logic                  s_axis_tuser  = 1'b0; // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // found_value, found_slot, 0s
    logic                  m_axis_tuser;        // found

    ring_scoreboard sb = new;
    int unsigned    send_idle_pct    = 31;
    int unsigned    recv_idle_pct    = 65;
    bit             hold_request     = 1'b0;
    bit             full_ring_probed = 1'b0;
    logic [63:0]    run_key;

    sorted_ring_index_cache_top #(.CAPACITY(RING_DEPTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d searches outstanding", sb.lookups_due.size());
        $display("tb_sorted_ring_index_cache_top: errors");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // key of some written slot, so that most searches hit
    function automatic logic [63:0] held_key();
        if (sb.fill_cnt == 0) return rand64();
        return sb.key_mem[$urandom_range(0, sb.fill_cnt - 1)];
    endfunction

    task automatic send_item(input t_opcode op, input logic [63:0] key,
                             input logic [63:0] val);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, key};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(op, key, val);
    endtask

    task automatic random_item();
        int unsigned pick;
        logic [63:0] key;
        logic [63:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            if (pick < 2) begin
                key = rand64();  // out-of-order noise, run continues afterwards
            end else begin
                step = (pick < 10) ? 64'($urandom_range(2, 5))
                                   : (rand64() >> $urandom_range(9, 10)) + 64'd2;
                key = run_key + step;
                // overflow past the top: restart the run near the bottom
                if ($signed(key) <= $signed(run_key)) key = KEY_MIN + 64'($urandom);
                run_key = key;
            end
            send_item(OP_APPEND, key, rand64());
            // full ring not yet wrapped: a single segment of full length
            if (sb.fill_cnt == RING_DEPTH && sb.wr_ptr == 0 && !full_ring_probed) begin
                full_ring_probed = 1'b1;
                repeat (3) send_item(OP_SEARCH, held_key(), rand64());
            end
        end else begin
            if (pick < 88)      key = held_key();
            else if (pick < 95) key = held_key() + 64'd1;
            else                key = rand64();
            send_item(OP_SEARCH, key, rand64());
        end
    endtask

    initial begin : result_sink
        int unsigned hold_left;
        t_lookup     got;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got.hit   = m_axis_tuser;
                got.value = m_axis_tdata[VAL_W-1:0];
                got.slot  = m_axis_tdata[VAL_W +: SLOT_W];
                sb.check_result(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int unsigned guard;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty ring, signed extremes, misses, repeated and falling keys
        send_item(OP_SEARCH, 64'd0, rand64());
        send_item(OP_APPEND, KEY_MIN, KEY_MAX);
        send_item(OP_APPEND, 64'hffff_ffff_ffff_ffff, KEY_MIN);
        send_item(OP_APPEND, 64'd0, 64'd0);
        send_item(OP_APPEND, 64'd1, 64'hffff_ffff_ffff_ffff);
        send_item(OP_SEARCH, KEY_MIN, rand64());
        send_item(OP_SEARCH, 64'hffff_ffff_ffff_ffff, rand64());
        send_item(OP_SEARCH, 64'd0, rand64());
        send_item(OP_SEARCH, 64'd1, rand64());
        send_item(OP_SEARCH, 64'd2, rand64());
        send_item(OP_SEARCH, 64'hffff_ffff_ffff_fffe, rand64());
        send_item(OP_SEARCH, KEY_MAX, rand64());
        send_item(OP_APPEND, KEY_MAX, 64'h5555_5555_5555_5555);
        send_item(OP_SEARCH, KEY_MAX, rand64());
        send_item(OP_APPEND, 64'd0, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(OP_SEARCH, 64'd0, rand64());
        send_item(OP_SEARCH, KEY_MIN + 64'd1, rand64());
        send_item(OP_APPEND, KEY_MIN, 64'd1);
        send_item(OP_SEARCH, KEY_MIN, rand64());

        run_key = KEY_MIN + 64'd16;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 3) begin
                send_idle_pct = 65;
                recv_idle_pct = 31;
            end else if (i == 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request  = 1'b1;  // long sink stall while items keep coming
            end
            random_item();
        end
        s_axis_tvalid <= 1'b0;

        guard = 0;
        while (sb.lookups_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.lookups_due.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d search results never arrived, oldest expected found=%0b",
                     $time, sb.lookups_due.size(), sb.lookups_due[0].hit);
        end

        $display("run: %0d appends, %0d searches (%0d hits, %0d over a wrapped ring)",
                 sb.n_append, sb.n_search, sb.n_hit, sb.n_split);
        $display("run: %0d results checked, %0d mismatches", sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_sorted_ring_index_cache_top: clean");
        end else begin
            $display("tb_sorted_ring_index_cache_top: errors");
        end
        $finish;
    end

endmodule
